FILE: hw/rtl/pvs_pkg.sv
// shared types and constants for the periodic variable sampler
`timescale 1ns / 1ps
`default_nettype none
package pvs_pkg;

  // input kind codes
  localparam logic [2:0] KIND_REG   = 3'd0;
  localparam logic [2:0] KIND_CLEAR = 3'd1;
  localparam logic [2:0] KIND_START = 3'd2;
  localparam logic [2:0] KIND_STOP  = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // result kinds
  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    OP_REG,
    OP_CLEAR,
    OP_START,
    OP_STOP,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] phase;
    logic [31:0] period;
    logic [31:0] addr;
    logic [15:0] size;
  } cmd_t;

  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] period;
    logic [31:0] addr;
    logic [15:0] size;
  } row_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD,
    B_LD,
    B_DIV,
    B_CMP,
    B_FLUSH
  } back_e;

endpackage
`default_nettype wire

FILE: hw/rtl/pvs_front.sv
// front end: accepts transactions, decodes the kind and queues commands
`timescale 1ns / 1ps
`default_nettype none
module pvs_front
  import pvs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] phase_i,
  input  wire logic [31:0] period_i,
  input  wire logic [31:0] var_address_i,
  input  wire logic [15:0] var_size_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  wire logic        cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       known;
  logic       push;
  op_e        op;

  // kind decode, unknown kinds are dropped
  always_comb begin
    known = 1'b1;
    op    = OP_TICK;
    case (kind_i)
      KIND_REG:   op = OP_REG;
      KIND_CLEAR: op = OP_CLEAR;
      KIND_START: op = OP_START;
      KIND_STOP:  op = OP_STOP;
      KIND_TICK:  op = OP_TICK;
      default:    known = 1'b0;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && known;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];

  // pointer and count update
  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = cmd_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= '{op: op, phase: phase_i, period: period_i,
                         addr: var_address_i, size: var_size_i};
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pvs_back.sv
// back end: schedule table, command execution, tick walk and result register
`timescale 1ns / 1ps
`default_nettype none
module pvs_back
  import pvs_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [1:0]       status_o,
  output logic [31:0]      sample_address_o,
  output logic [15:0]      sample_size_o,
  output logic [31:0]      sample_tick_o,
  output logic             last_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  row_t        mem [TABLE_DEPTH];
  row_t        rd_q, row_q, row_d;
  back_e       state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] rows_q, rows_d;
  logic        run_q, run_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] rem_q, rem_d, dvd_q, dvd_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        pend_q, pend_d;
  logic [31:0] pend_addr_q, pend_addr_d;
  logic [15:0] pend_size_q, pend_size_d;
  logic        ovalid_q;
  logic        okind_q;
  logic [1:0]  ostat_q;
  logic [31:0] oaddr_q, otick_q;
  logic [15:0] osize_q;
  logic        olast_q;
  logic        out_free, we;
  logic        emit, e_kind, e_last;
  logic [1:0]  e_stat;
  logic [31:0] e_addr, e_tick;
  logic [15:0] e_size;
  logic [32:0] trial;
  logic        match, last_row, cmp_wait, flush_wait, full;

  assign out_free   = !ovalid_q || !out_stall_i;
  assign trial      = {rem_q, dvd_q[31]};
  assign match      = (row_q.period != 32'd0) && (rem_q == row_q.phase);
  assign last_row   = ((CW'(idx_q) + CW'(1)) == rows_q);
  assign cmp_wait   = match && pend_q && !out_free;
  assign flush_wait = pend_q && !out_free;
  assign full       = (rows_q >= CW'(TABLE_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i && out_free && cmd_i.op == OP_TICK && run_q) state_d = B_RD;
      end
      B_RD:  state_d = B_LD;
      B_LD:  state_d = B_DIV;
      B_DIV: begin
        if (cnt_q == 5'd31) state_d = B_CMP;
      end
      B_CMP: begin
        if (!cmp_wait) state_d = last_row ? B_FLUSH : B_RD;
      end
      B_FLUSH: begin
        if (!flush_wait) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and result selection
  always_comb begin
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    idx_d       = idx_q;
    rows_d      = rows_q;
    run_d       = run_q;
    tick_d      = tick_q;
    row_d       = row_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pend_size_d = pend_size_q;
    emit        = 1'b0;
    e_kind      = RK_STATUS;
    e_stat      = ST_OK;
    e_addr      = 32'd0;
    e_size      = 16'd0;
    e_tick      = 32'd0;
    e_last      = 1'b1;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_REG: begin
              emit = 1'b1;
              if (full) begin
                e_stat = ST_FULL;
              end else begin
                we     = 1'b1;
                rows_d = rows_q + CW'(1);
              end
            end
            OP_CLEAR: begin
              emit   = 1'b1;
              run_d  = 1'b0;
              rows_d = '0;
            end
            OP_START: begin
              emit = 1'b1;
              if (rows_q == '0) begin
                e_stat = ST_EMPTY;
              end else begin
                run_d  = 1'b1;
                tick_d = 32'd0;
              end
            end
            OP_STOP: begin
              emit  = 1'b1;
              run_d = 1'b0;
            end
            OP_TICK: begin
              idx_d  = '0;
              pend_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      B_LD: begin
        row_d = rd_q;
        rem_d = 32'd0;
        dvd_d = tick_q;
        cnt_d = 5'd0;
      end
      // restoring division, one quotient bit a cycle
      B_DIV: begin
        if (trial >= {1'b0, row_q.period}) rem_d = 32'(trial - {1'b0, row_q.period});
        else rem_d = trial[31:0];
        dvd_d = {dvd_q[30:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
      end
      // hold one match back so the final one can carry last
      B_CMP: begin
        if (!cmp_wait) begin
          if (match) begin
            if (pend_q) begin
              emit   = 1'b1;
              e_kind = RK_SAMPLE;
              e_addr = pend_addr_q;
              e_size = pend_size_q;
              e_tick = tick_q;
              e_last = 1'b0;
            end
            pend_d      = 1'b1;
            pend_addr_d = row_q.addr;
            pend_size_d = row_q.size;
          end
          if (!last_row) idx_d = idx_q + IW'(1);
        end
      end
      B_FLUSH: begin
        if (!flush_wait) begin
          if (pend_q) begin
            emit   = 1'b1;
            e_kind = RK_SAMPLE;
            e_addr = pend_addr_q;
            e_size = pend_size_q;
            e_tick = tick_q;
          end
          pend_d = 1'b0;
          tick_d = tick_q + 32'd1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      rows_q   <= '0;
      run_q    <= 1'b0;
      tick_q   <= 32'd0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      cnt_q    <= 5'd0;
    end else begin
      state_q  <= state_d;
      rows_q   <= rows_d;
      run_q    <= run_d;
      tick_q   <= tick_d;
      pend_q   <= pend_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      if (emit) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    pend_addr_q <= pend_addr_d;
    pend_size_q <= pend_size_d;
    if (emit) begin
      okind_q <= e_kind;
      ostat_q <= e_stat;
      oaddr_q <= e_addr;
      osize_q <= e_size;
      otick_q <= e_tick;
      olast_q <= e_last;
    end
  end

  // schedule table, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[rows_q[IW-1:0]] <= '{phase: cmd_i.phase, period: cmd_i.period,
                               addr: cmd_i.addr, size: cmd_i.size};
    end
    rd_q <= mem[idx_q];
  end

  assign out_valid_o      = ovalid_q;
  assign result_kind_o    = okind_q;
  assign status_o         = ostat_q;
  assign sample_address_o = oaddr_q;
  assign sample_size_o    = osize_q;
  assign sample_tick_o    = otick_q;
  assign last_o           = olast_q;

endmodule
`default_nettype wire

FILE: hw/rtl/periodic_variable_sampler_core.sv
// periodic variable sampler top level
// a control transaction is queued, executed by the back end when it is idle, and its reply registered
// tick: each table row is read, loaded, run through a 32-step serial divider and compared,
//   then a flush state sends any held sample and advances the tick
// a two-entry command queue lets input transactions be taken during a walk
// reset: asynchronous active low, empties the table, stops sampling, zeroes the tick
`timescale 1ns / 1ps
`default_nettype none
module periodic_variable_sampler_core
  import pvs_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] phase_i,
  input  wire logic [31:0] period_i,
  input  wire logic [31:0] var_address_i,
  input  wire logic [15:0] var_size_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [1:0]       status_o,
  output logic [31:0]      sample_address_o,
  output logic [15:0]      sample_size_o,
  output logic [31:0]      sample_tick_o,
  output logic             last_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // decode and queue
  pvs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .phase_i, .period_i,
    .var_address_i, .var_size_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // execute
  pvs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o, .out_stall_i, .result_kind_o, .status_o, .sample_address_o,
    .sample_size_o, .sample_tick_o, .last_o
  );

endmodule
`default_nettype wire

FILE: hw/rtl/pvs_checker.sv
// port level checks for the sampler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module pvs_checker
  import pvs_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_stall_i,
  input wire logic        result_kind_i,
  input wire logic [1:0]  status_i,
  input wire logic [31:0] sample_address_i,
  input wire logic [15:0] sample_size_i,
  input wire logic [31:0] sample_tick_i,
  input wire logic        last_i
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(sample_tick_i)
      && $stable(sample_address_i) && $stable(last_i) && $stable(result_kind_i))
    else $error("stalled result changed");

  // status replies are single and complete
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i == RK_STATUS |-> last_i && sample_tick_i == 32'd0
      && sample_address_i == 32'd0 && sample_size_i == 16'd0)
    else $error("malformed status reply");

  // samples carry ok status
  a_sample_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i == RK_SAMPLE |-> status_i == ST_OK)
    else $error("sample with nonzero status");

  // samples of one tick share the tick value
  a_same_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && result_kind_i == RK_SAMPLE && !last_i
      ##1 out_valid_i |-> result_kind_i == RK_SAMPLE && sample_tick_i == $past(sample_tick_i))
    else $error("sample group broken");

endmodule

bind periodic_variable_sampler_core pvs_checker u_pvs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .result_kind_i    (result_kind_o),
  .status_i         (status_o),
  .sample_address_i (sample_address_o),
  .sample_size_i    (sample_size_o),
  .sample_tick_i    (sample_tick_o),
  .last_i           (last_o)
);
`default_nettype wire

FILE: test/periodic_variable_sampler_core_test.sv
// self-checking testbench for the periodic variable sampler core
`timescale 1ns / 1ps
module periodic_variable_sampler_core_test;
  import pvs_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 2000000;
  // drain time covers the longest tick walk over a full table
  localparam int DRAIN_CYCLES = 35 * DEPTH + 50;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] phase;
    logic [31:0] period;
    logic [31:0] addr;
    logic [15:0] size;
  } txn_t;

  typedef struct packed {
    logic        rkind;
    logic [1:0]  status;
    logic [31:0] addr;
    logic [15:0] size;
    logic [31:0] tick;
    logic        last;
  } reply_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] kind;
  logic [31:0] phase, period, var_addr;
  logic [15:0] var_size;
  logic result_kind, last;
  logic [1:0] status;
  logic [31:0] sample_addr, sample_tick;
  logic [15:0] sample_size;

  periodic_variable_sampler_core #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .phase_i(phase), .period_i(period),
    .var_address_i(var_addr), .var_size_i(var_size),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_kind_o(result_kind), .status_o(status),
    .sample_address_o(sample_addr), .sample_size_o(sample_size),
    .sample_tick_o(sample_tick), .last_o(last)
  );

  // schedule table mirror
  logic [31:0] tbl_phase [DEPTH];
  logic [31:0] tbl_period [DEPTH];
  logic [31:0] tbl_addr [DEPTH];
  logic [15:0] tbl_size [DEPTH];
  int unsigned tbl_used;
  bit sampling;
  logic [31:0] tick_cnt;

  txn_t pending_q[$];
  reply_t replies_q[$];
  int errors;
  int unsigned cycles;
  bit quiet;        // no idling in the final part
  bit hold_send;    // sender pause requested
  int send_gap, recv_gap;

  function automatic reply_t status_reply(logic [1:0] code);
    reply_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    return r;
  endfunction

  // compute the replies of one accepted transaction
  task automatic predict_replies(txn_t t);
    reply_t r;
    int first;
    first = replies_q.size();
    case (t.kind)
      KIND_REG: begin
        if (tbl_used >= DEPTH) replies_q.push_back(status_reply(ST_FULL));
        else begin
          tbl_phase[tbl_used] = t.phase;
          tbl_period[tbl_used] = t.period;
          tbl_addr[tbl_used] = t.addr;
          tbl_size[tbl_used] = t.size;
          tbl_used++;
          replies_q.push_back(status_reply(ST_OK));
        end
      end
      KIND_CLEAR: begin
        sampling = 0;
        tbl_used = 0;
        replies_q.push_back(status_reply(ST_OK));
      end
      KIND_START: begin
        if (tbl_used == 0) replies_q.push_back(status_reply(ST_EMPTY));
        else begin
          sampling = 1;
          tick_cnt = '0;
          replies_q.push_back(status_reply(ST_OK));
        end
      end
      KIND_STOP: begin
        sampling = 0;
        replies_q.push_back(status_reply(ST_OK));
      end
      KIND_TICK: begin
        if (sampling) begin
          for (int i = 0; i < tbl_used; i++) begin
            if (tbl_period[i] != 0 && tick_cnt % tbl_period[i] == tbl_phase[i]) begin
              r = '0;
              r.rkind = RK_SAMPLE;
              r.addr = tbl_addr[i];
              r.size = tbl_size[i];
              r.tick = tick_cnt;
              replies_q.push_back(r);
            end
          end
          if (replies_q.size() > first) replies_q[$].last = 1'b1;
          tick_cnt = tick_cnt + 1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic txn_t mk(logic [2:0] k, logic [31:0] ph = 0, logic [31:0] pr = 0,
                              logic [31:0] a = 0, logic [15:0] s = 0);
    txn_t t;
    t.kind = k; t.phase = ph; t.period = pr; t.addr = a; t.size = s;
    return t;
  endfunction

  function automatic txn_t rnd_row();
    int sel;
    logic [31:0] pr;
    sel = $urandom_range(0, 9);
    pr = (sel == 0) ? 32'd0 : (sel == 1) ? $urandom : $urandom_range(1, 6);
    return mk(KIND_REG, (sel < 8) ? $urandom_range(0, pr == 0 ? 3 : pr - 1) : $urandom,
              pr, $urandom, 16'($urandom_range(0, 16'hffff)));
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      send_gap <= 0;
    end else if (in_valid && !in_stall) begin
      predict_replies({kind, phase, period, var_addr, var_size});
      if (!quiet && $urandom_range(0, 5) == 0) begin
        in_valid <= 0;
        send_gap <= $urandom_range(1, 4) - 1;
      end else if (pending_q.size() > 0 && !hold_send) begin
        {kind, phase, period, var_addr, var_size} <= pending_q.pop_front();
      end else in_valid <= 0;
    end else if (!in_valid) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (pending_q.size() > 0 && !hold_send) begin
        {kind, phase, period, var_addr, var_size} <= pending_q.pop_front();
        in_valid <= 1;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    reply_t got, exp_r;
    if (!rst_n) begin
      out_stall <= 0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {result_kind, status, sample_addr, sample_size, sample_tick, last};
        if (replies_q.size() == 0) begin
          $display("%0t unexpected reply: actual %h", $time, got);
          errors++;
        end else begin
          exp_r = replies_q.pop_front();
          if (got.rkind !== exp_r.rkind) begin
            $display("%0t result_kind expected %h actual %h", $time, exp_r.rkind, got.rkind);
            errors++;
          end
          if (got.status !== exp_r.status) begin
            $display("%0t status expected %h actual %h", $time, exp_r.status, got.status);
            errors++;
          end
          if (got.addr !== exp_r.addr) begin
            $display("%0t sample_address expected %h actual %h", $time, exp_r.addr, got.addr);
            errors++;
          end
          if (got.size !== exp_r.size) begin
            $display("%0t sample_size expected %h actual %h", $time, exp_r.size, got.size);
            errors++;
          end
          if (got.tick !== exp_r.tick) begin
            $display("%0t sample_tick expected %h actual %h", $time, exp_r.tick, got.tick);
            errors++;
          end
          if (got.last !== exp_r.last) begin
            $display("%0t last expected %h actual %h", $time, exp_r.last, got.last);
            errors++;
          end
        end
      end
      if (recv_gap > 0) recv_gap <= recv_gap - 1;
      else if (out_stall) out_stall <= 0;
      else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        recv_gap <= $urandom_range(1, 4) - 1;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || replies_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int r;
    txn_t t;
    rst_n = 0; in_valid = 0; out_stall = 0;
    kind = '0; phase = '0; period = '0; var_addr = '0; var_size = '0;
    tbl_used = 0; sampling = 0; tick_cnt = '0;
    errors = 0; cycles = 0; quiet = 0; hold_send = 0;
    send_gap = 0; recv_gap = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: empty start, idle tick, stop while stopped, unknown kinds
    pending_q.push_back(mk(KIND_START));
    pending_q.push_back(mk(KIND_TICK));
    pending_q.push_back(mk(KIND_STOP));
    pending_q.push_back(mk(3'd5, '1, '1, '1, '1));
    pending_q.push_back(mk(3'd7, '1, '1, '1, '1));
    pending_q.push_back(mk(3'd6));
    // rows: zero period, extremes, small periods
    pending_q.push_back(mk(KIND_REG, 0, 0, 32'h1111_0000, 16'h0001));
    pending_q.push_back(mk(KIND_REG, 0, 1, '0, '0));
    pending_q.push_back(mk(KIND_REG, 1, 2, '1, '1));
    pending_q.push_back(mk(KIND_REG, '1, '1, 32'hA5A5_5A5A, 16'h8000));
    pending_q.push_back(mk(KIND_REG, 5, 3, 32'h0000_0042, 16'h0004));
    pending_q.push_back(mk(KIND_START));
    repeat (4) pending_q.push_back(mk(KIND_TICK));
    pending_q.push_back(mk(KIND_START));  // restart while running
    pending_q.push_back(mk(KIND_TICK));
    pending_q.push_back(mk(KIND_STOP));
    pending_q.push_back(mk(KIND_TICK));   // stopped tick
    pending_q.push_back(mk(KIND_CLEAR));
    pending_q.push_back(mk(KIND_TICK));
    pending_q.push_back(mk(KIND_START));
    wait_idle();

    // fill the table to overflow with random rows, then tick
    hold_send = 1;
    for (int i = 0; i < DEPTH; i++) pending_q.push_back(rnd_row());
    pending_q.push_back(mk(KIND_REG, '1, '1, '1, '1));
    pending_q.push_back(mk(KIND_START));
    repeat (3) pending_q.push_back(mk(KIND_TICK));
    hold_send = 0;
    wait_idle();  // wait until all transactions are sent and all replies came
    repeat (DRAIN_CYCLES) @(posedge clk);

    // random sequences: clear, a few rows, start, ticks, stops, noise
    for (int s = 0; s < 2; s++) begin
      if (s == 1) quiet = 1;
      pending_q.push_back(mk(KIND_CLEAR));
      r = $urandom_range(1, 5);
      for (int i = 0; i < r; i++) pending_q.push_back(rnd_row());
      pending_q.push_back(mk(KIND_START));
      r = $urandom_range(3, 8);
      for (int i = 0; i < r; i++) begin
        case ($urandom_range(0, 9))
          0: begin
            t = mk(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                   16'($urandom_range(0, 16'hffff)));
            pending_q.push_back(t);
          end
          1: pending_q.push_back(mk(KIND_STOP));
          default: pending_q.push_back(mk(KIND_TICK));
        endcase
      end
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && replies_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
